/* rtl/sorted_unique_set_insert_unit_assert.svh */
// assertion macros for the sorted unique set insert unit
`ifndef SORTED_UNIQUE_SET_INSERT_UNIT_ASSERT_SVH
`define SORTED_UNIQUE_SET_INSERT_UNIT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, masked while rst_n is low
`define SUSET_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("suset assertion failed");

// next-cycle implication, sampled on clk, masked while rst_n is low
`define SUSET_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("suset assertion failed");

`else

`define SUSET_ASSERT_IMP(label, ante, cons)
`define SUSET_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* rtl/suset_pkg.sv */
// shared constants, codes and control types of the sorted unique set insert unit
package suset_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 16;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMD_W      = 2;
  localparam int ST_W       = 3;
  localparam int ENTRY_W    = 16;
  localparam int TDATA_IN_W = 16;
  localparam int TDATA_OUT_W = 24;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_DUMPED    = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic capture;    // take the accepted item into the item register
    logic exec;       // carry out the held command
    logic dump_step;  // emit the next dumped entry
  } suset_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_dump;    // held command is a dump
    logic no_result;  // held command is the unused code
    logic multi;      // more than one entry stored
    logic dump_last;  // dump index points at the final entry
  } suset_sts_t;

endpackage

/* rtl/suset_ctrl.sv */
// controller state machine of the sorted unique set insert unit
module suset_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  input  suset_pkg::suset_sts_t sts_i,
  output suset_pkg::suset_cmd_t cmd_o
);
  import suset_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       out_load;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt       = state_r;
    cmd_o.capture   = 1'b0;
    cmd_o.exec      = 1'b0;
    cmd_o.dump_step = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free || sts_i.no_result) begin
          cmd_o.exec = 1'b1;
          state_nxt  = (sts_i.is_dump && sts_i.multi) ? S_DUMP : S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          cmd_o.dump_step = 1'b1;
          if (sts_i.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_load = (cmd_o.exec && !sts_i.no_result) || cmd_o.dump_step;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`include "sorted_unique_set_insert_unit_assert.svh"

  `SUSET_ASSERT_NXT(a_accept_then_exec, in_tvalid && in_tready, state_r == S_EXEC)
  `SUSET_ASSERT_IMP(a_load_needs_room, out_load, out_free)
  `SUSET_ASSERT_IMP(a_dump_has_many, state_r == S_DUMP, sts_i.multi && sts_i.is_dump)
  `SUSET_ASSERT_NXT(a_load_shows_valid, out_load, out_valid_r)

endmodule

/* rtl/suset_dp.sv */
// datapath of the sorted unique set insert unit: entry row, fill count, result register
module suset_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [suset_pkg::CMD_W-1:0]      item_cmd,
  input  logic [suset_pkg::VALUE_BITS-1:0] item_value,
  input  suset_pkg::suset_cmd_t            cmd_i,
  output suset_pkg::suset_sts_t            sts_o,
  output logic [suset_pkg::ST_W-1:0]       res_status,
  output logic [suset_pkg::ENTRY_W-1:0]    res_entry,
  output logic [suset_pkg::CNT_W-1:0]      res_count,
  output logic                             res_empty,
  output logic                             res_last
);
  import suset_pkg::*;

  logic [CMD_W-1:0]      cmd_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] entries_r [DEPTH];
  logic [VALUE_BITS-1:0] ins_nxt   [DEPTH];
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [DEPTH-1:0]      lt, eq;
  logic                  dup, full, do_write;

  logic [ST_W-1:0]       st_nxt;
  logic [ENTRY_W-1:0]    ent_nxt;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  last_nxt;
  logic                  load;

  // parallel compare against every stored entry
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < fill_r) && (entries_r[i] < val_r);
      eq[i] = (CNT_W'(i) < fill_r) && (entries_r[i] == val_r);
    end
  end

  assign dup  = |eq;
  assign full = (fill_r == CNT_W'(DEPTH));

  // lt is a prefix: keep below it, place the value at its edge, shift above
  always_comb begin
    ins_nxt[0] = lt[0] ? entries_r[0] : val_r;
    for (int i = 1; i < DEPTH; i++) begin
      if (lt[i]) begin
        ins_nxt[i] = entries_r[i];
      end else if (lt[i-1]) begin
        ins_nxt[i] = val_r;
      end else begin
        ins_nxt[i] = entries_r[i-1];
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    idx_nxt  = idx_r;
    do_write = 1'b0;
    st_nxt   = ST_EMPTY;
    ent_nxt  = '0;
    cnt_nxt  = '0;
    last_nxt = 1'b1;
    load     = 1'b0;
    if (cmd_i.exec) begin
      case (cmd_r)
        CMD_INSERT: begin
          load    = 1'b1;
          ent_nxt = ENTRY_W'(val_r);
          if (dup) begin
            st_nxt = ST_DUPLICATE;
          end else if (full) begin
            st_nxt = ST_FULL;
          end else begin
            st_nxt   = ST_INSERTED;
            do_write = 1'b1;
            fill_nxt = fill_r + CNT_W'(1);
          end
          cnt_nxt = fill_nxt;
        end
        CMD_DUMP: begin
          load = 1'b1;
          if (fill_r != '0) begin
            st_nxt   = ST_DUMPED;
            ent_nxt  = ENTRY_W'(entries_r[0]);
            cnt_nxt  = fill_r;
            last_nxt = (fill_r == CNT_W'(1));
            idx_nxt  = IDX_W'(1);
          end
        end
        CMD_CLEAR: begin
          load     = 1'b1;
          fill_nxt = '0;
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end else if (cmd_i.dump_step) begin
      load     = 1'b1;
      st_nxt   = ST_DUMPED;
      ent_nxt  = ENTRY_W'(entries_r[idx_r]);
      cnt_nxt  = fill_r;
      last_nxt = sts_o.dump_last;
      idx_nxt  = idx_r + IDX_W'(1);
    end
  end

  assign sts_o.is_dump   = (cmd_r == CMD_DUMP);
  assign sts_o.no_result = (cmd_r != CMD_INSERT) && (cmd_r != CMD_DUMP) &&
                           (cmd_r != CMD_CLEAR);
  assign sts_o.multi     = (fill_r > CNT_W'(1));
  assign sts_o.dump_last = ((CNT_W'(idx_r) + CNT_W'(1)) == fill_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      idx_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      cmd_r <= item_cmd;
      val_r <= item_value;
    end
    if (do_write) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries_r[i] <= ins_nxt[i];
      end
    end
    if (load) begin
      res_status <= st_nxt;
      res_entry  <= ent_nxt;
      res_count  <= cnt_nxt;
      res_empty  <= (cnt_nxt == '0);
      res_last   <= last_nxt;
    end
  end

endmodule

/* rtl/sorted_unique_set_insert_unit.sv */
// top level of the sorted unique set insert unit
// Keeps up to 16 distinct 16-bit vertex numbers in ascending order. An insert
// (tuser 0) places in_tdata in sorted position and returns one transfer with
// status inserted, duplicate rejected (checked before capacity) or full dropped.
// A dump (tuser 1) returns every stored entry in ascending order, tlast on the
// final one, or a single empty-status transfer when nothing is stored; a clear
// (tuser 2) empties the set and returns one empty-status transfer. Code 3 is
// ignored with no output. An item is captured into the item register and
// executed from it once the result register is free (code 3 at once); no new
// item is taken until an item, or a whole dump, is through. A dump reads out
// a single stored entry per cycle while the result register is free. The
// result register lets the next item be taken while a result waits.
// There is no clearing pass: the fill count alone marks the valid entries.
module sorted_unique_set_insert_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [suset_pkg::TDATA_IN_W-1:0]  in_tdata,   // value[15:0]
  input  logic [suset_pkg::CMD_W-1:0]       in_tuser,   // cmd[1:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [suset_pkg::TDATA_OUT_W-1:0] out_tdata,  // entry[15:0], count[20:16],
                                                        // is_empty[21], zero[23:22]
  output logic [suset_pkg::ST_W-1:0]        out_tuser,  // status[2:0]
  output logic                              out_tlast
);
  import suset_pkg::*;

  suset_cmd_t         cmd;
  suset_sts_t         sts;
  logic [ST_W-1:0]    res_status;
  logic [ENTRY_W-1:0] res_entry;
  logic [CNT_W-1:0]   res_count;
  logic               res_empty;
  logic               res_last;

  // sequencing and output handshake
  suset_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // entry row, compare and shift, result register
  suset_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_cmd   (in_tuser),
    .item_value (in_tdata[VALUE_BITS-1:0]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_status (res_status),
    .res_entry  (res_entry),
    .res_count  (res_count),
    .res_empty  (res_empty),
    .res_last   (res_last)
  );

  // pack result fields, lowest bit first, padded to whole bytes
  assign out_tdata = {2'b00, res_empty, res_count, res_entry};
  assign out_tuser = res_status;
  assign out_tlast = res_last;

endmodule
